// File: sv/sjn_pkg.sv
`timescale 1ns / 1ps
package sjn_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 16;
  localparam int DEF_LENGTH_BITS = 16;

  localparam int FIELD_BITS    = 16;
  localparam int COUNT_BITS    = 5;
  localparam int IN_DATA_BITS  = 32;
  localparam int OUT_DATA_BITS = 48;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_ZERO_LEN = 2'd1;
  localparam status_t STATUS_FULL     = 2'd2;

  localparam logic REQ_ARRIVE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WAIT_INSERT,
    ST_WAIT_POP,
    ST_TICK,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    Q_IDLE,
    Q_CMP,
    Q_PLACE,
    Q_POP
  } qstate_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } qcmd_t;

  typedef struct packed {
    logic done;
    logic full;
    logic empty;
  } qstat_t;

endpackage

// File: sv/sjn_ram.sv
`timescale 1ns / 1ps
module sjn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/sjn_queue.sv
`timescale 1ns / 1ps
module sjn_ready_queue import sjn_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_W        = FIELD_BITS,
  parameter int LEN_W       = FIELD_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  qcmd_t                            cmd,
  input  logic [ID_W-1:0]                  in_id,
  input  logic [LEN_W-1:0]                 in_len,
  output qstat_t                           stat,
  output logic [ID_W-1:0]                  pop_id,
  output logic [LEN_W-1:0]                 pop_len,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

  localparam int AddrW = $clog2(QUEUE_DEPTH);
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SumW  = CntW + 1;
  localparam int EntW  = ID_W + LEN_W;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(QUEUE_DEPTH - 1);

  function automatic logic [AddrW-1:0] dec_addr(input logic [AddrW-1:0] a);
    return (a == '0) ? LastAddr : a - 1'b1;
  endfunction

  function automatic logic [AddrW-1:0] inc_addr(input logic [AddrW-1:0] a);
    return (a == LastAddr) ? '0 : a + 1'b1;
  endfunction

  qstate_t          qstate, qstate_next;
  logic [AddrW-1:0] head, wp, rp, tail;
  logic [CntW-1:0]  rem;
  logic [ID_W-1:0]  new_id;
  logic [LEN_W-1:0] new_len;
  logic [SumW-1:0]  tail_sum;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [EntW-1:0]  wdata, rdata;
  logic             shift;

  assign tail_sum = SumW'(head) + SumW'(count);
  assign tail = (tail_sum >= SumW'(QUEUE_DEPTH)) ? AddrW'(tail_sum - SumW'(QUEUE_DEPTH))
                                                 : AddrW'(tail_sum);

  assign pop_len = rdata[LEN_W-1:0];
  assign pop_id  = rdata[EntW-1:LEN_W];
  // entry ahead of the new one is longer: move it one slot back
  assign shift   = pop_len > new_len;

  sjn_ram #(
    .WIDTH(EntW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    qstate_next = qstate;
    case (qstate)
      Q_IDLE: begin
        if (cmd.insert) begin
          qstate_next = (count == '0) ? Q_PLACE : Q_CMP;
        end else if (cmd.pop) begin
          qstate_next = Q_POP;
        end
      end
      Q_CMP: begin
        if (!shift) begin
          qstate_next = Q_IDLE;
        end else if (rem == CntW'(1)) begin
          qstate_next = Q_PLACE;
        end
      end
      Q_PLACE: qstate_next = Q_IDLE;
      Q_POP:   qstate_next = Q_IDLE;
      default: qstate_next = Q_IDLE;
    endcase
  end

  always_comb begin
    we         = 1'b0;
    waddr      = wp;
    wdata      = {new_id, new_len};
    raddr      = dec_addr(rp);
    stat.done  = 1'b0;
    stat.full  = (count == CntW'(QUEUE_DEPTH));
    stat.empty = (count == '0);
    case (qstate)
      Q_IDLE: begin
        raddr = cmd.pop ? head : dec_addr(tail);
      end
      Q_CMP: begin
        we = 1'b1;
        if (shift) begin
          wdata = rdata;
        end else begin
          stat.done = 1'b1;
        end
      end
      Q_PLACE: begin
        we        = 1'b1;
        stat.done = 1'b1;
      end
      Q_POP: begin
        stat.done = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qstate <= Q_IDLE;
      head   <= '0;
      count  <= '0;
    end else begin
      qstate <= qstate_next;
      case (qstate)
        Q_CMP: begin
          if (!shift) begin
            count <= count + 1'b1;
          end
        end
        Q_PLACE: count <= count + 1'b1;
        Q_POP: begin
          head  <= inc_addr(head);
          count <= count - 1'b1;
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (qstate)
      Q_IDLE: begin
        if (cmd.insert) begin
          new_id  <= in_id;
          new_len <= in_len;
          wp      <= tail;
          rp      <= dec_addr(tail);
          rem     <= count;
        end
      end
      Q_CMP: begin
        if (shift) begin
          wp  <= rp;
          rp  <= dec_addr(rp);
          rem <= rem - 1'b1;
        end
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

endmodule

// File: sv/shortest_job_next_scheduler_core.sv
`timescale 1ns / 1ps
// Non-preemptive shortest-job-next scheduler. Each request on the input stream is either an
// arrival (tuser 0, task id and length in tdata) or a tick (tuser 1), and each request yields
// exactly one result on the output stream. Waiting tasks sit in a circular buffer in one
// single-port-read RAM, kept sorted by length with equal lengths in arrival order. An arrival
// walks the queue from its tail one entry per clock through the RAM read port and the one
// length comparator; a rejected arrival goes straight to the finish state. A tick passes
// through the tick state, and first through a pop wait when it has to pull the shortest task
// out of the RAM. The block takes one request at a time; a finished result waits in the output
// register while the next request is accepted, and a stalled output side adds its wait on top.
module shortest_job_next_scheduler_core import sjn_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // task_id [15:0], task_length [31:16]
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // req_type
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // status [1:0], running_valid [2], running_id [18:3], done_valid [19],
  // done_id [35:20], queued_count [40:36], zero [47:41]
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

  localparam int IdW  = (ID_BITS < FIELD_BITS) ? ID_BITS : FIELD_BITS;
  localparam int LenW = (LENGTH_BITS < FIELD_BITS) ? LENGTH_BITS : FIELD_BITS;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int PadW = OUT_DATA_BITS - 2 * FIELD_BITS - COUNT_BITS - 4;

  state_t          state, state_next;
  logic            accept, is_tick, len_zero, out_load;
  logic [IdW-1:0]  in_id;
  logic [LenW-1:0] in_len;

  qcmd_t           qcmd;
  qstat_t          qstat;
  logic [IdW-1:0]  pop_id;
  logic [LenW-1:0] pop_len;
  logic [CntW-1:0] qcount;

  logic            run_active;
  logic [IdW-1:0]  run_id;
  logic [LenW-1:0] run_len, run_elapsed, elapsed_inc;

  status_t         res_status;
  logic            res_done;
  logic [IdW-1:0]  res_done_id;

  assign in_id       = IdW'(s_axis_tdata[FIELD_BITS-1:0]);
  assign in_len      = LenW'(s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]);
  assign is_tick     = (s_axis_tuser == REQ_TICK);
  assign len_zero    = (in_len == '0);
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign elapsed_inc = run_elapsed + 1'b1;

  sjn_ready_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_W       (IdW),
    .LEN_W      (LenW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .cmd    (qcmd),
    .in_id  (in_id),
    .in_len (in_len),
    .stat   (qstat),
    .pop_id (pop_id),
    .pop_len(pop_len),
    .count  (qcount)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_tick) begin
            state_next = (!run_active && !qstat.empty) ? ST_WAIT_POP : ST_TICK;
          end else if (len_zero || qstat.full) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_WAIT_INSERT;
          end
        end
      end
      ST_WAIT_INSERT: begin
        if (qstat.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_WAIT_POP: begin
        if (qstat.done) begin
          state_next = ST_TICK;
        end
      end
      ST_TICK:   state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ST_IDLE);
    out_load      = (state == ST_FINISH) && (!m_axis_tvalid || m_axis_tready);
    qcmd.insert   = 1'b0;
    qcmd.pop      = 1'b0;
    case (state)
      ST_IDLE: begin
        qcmd.insert = accept && !is_tick && !len_zero && !qstat.full;
        qcmd.pop    = accept && is_tick && !run_active && !qstat.empty;
      end
      default: begin
        qcmd.insert = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      run_active    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == ST_WAIT_POP && qstat.done) begin
        run_active <= 1'b1;
      end else if (state == ST_TICK && run_active && elapsed_inc >= run_len) begin
        run_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          res_done <= 1'b0;
          if (is_tick) begin
            res_status <= STATUS_OK;
          end else if (len_zero) begin
            res_status <= STATUS_ZERO_LEN;
          end else if (qstat.full) begin
            res_status <= STATUS_FULL;
          end else begin
            res_status <= STATUS_OK;
          end
        end
      end
      ST_WAIT_POP: begin
        if (qstat.done) begin
          run_id      <= pop_id;
          run_len     <= pop_len;
          run_elapsed <= '0;
        end
      end
      ST_TICK: begin
        if (run_active) begin
          if (elapsed_inc >= run_len) begin
            res_done    <= 1'b1;
            res_done_id <= run_id;
            run_elapsed <= '0;
          end else begin
            run_elapsed <= elapsed_inc;
          end
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          m_axis_tdata <= {
            PadW'(0),
            COUNT_BITS'(qcount),
            res_done ? FIELD_BITS'(res_done_id) : FIELD_BITS'(0),
            res_done,
            run_active ? FIELD_BITS'(run_id) : FIELD_BITS'(0),
            run_active,
            res_status
          };
        end
      end
      default: begin
        res_done <= res_done;
      end
    endcase
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import sjn_pkg::*;

  localparam int QDEPTH = DEF_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 2 * QDEPTH + 10;

  typedef struct {
    logic            kind;
    logic [15:0]     id;
    logic [15:0]     len;
    int              gap;
  } sched_req_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] id;
    logic [FIELD_BITS-1:0] len;
  } job_t;

  typedef struct packed {
    status_t               status;
    logic                  run_v;
    logic [FIELD_BITS-1:0] run_id;
    logic                  done_v;
    logic [FIELD_BITS-1:0] done_id;
    logic [COUNT_BITS-1:0] queued;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  sched_req_t    req_backlog[$];
  sched_result_t sched_out_q[$];

  // scheduler mirror
  job_t            ready_q[$];
  logic            run_on = 1'b0;
  logic [15:0]     run_id = '0;
  logic [15:0]     run_len = '0;
  logic [15:0]     run_ticks = '0;

  logic req_taken = 1'b0;
  logic res_taken = 1'b0;
  int   cycles = 0;
  int   results_seen = 0;
  int   err_count = 0;
  int   tx_gap = 0;
  int   rx_wait = 0;
  int   hold_left = 0;
  bit   tx_calm = 1'b0;
  bit   rx_calm = 1'b0;

  shortest_job_next_scheduler_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < 100) begin
      $display("mismatch at cycle %0d: %s", cycles, msg);
    end
    err_count++;
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                results_seen, name, got, want));
    end
  endtask

  task automatic schedule_step(input logic kind, input logic [15:0] id,
                               input logic [15:0] len, output sched_result_t r);
    int   pos;
    job_t j;
    r = '0;
    if (kind == REQ_ARRIVE) begin
      if (len == 0) begin
        r.status = STATUS_ZERO_LEN;
      end else if (ready_q.size() >= QDEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < ready_q.size() && ready_q[pos].len <= len) pos++;
        j.id = id;
        j.len = len;
        ready_q.insert(pos, j);
        r.status = STATUS_OK;
      end
    end else begin
      r.status = STATUS_OK;
      if (!run_on && ready_q.size() > 0) begin
        j = ready_q.pop_front();
        run_id = j.id;
        run_len = j.len;
        run_ticks = '0;
        run_on = 1'b1;
      end
      if (run_on) begin
        run_ticks = run_ticks + 16'd1;
        if (run_ticks >= run_len) begin
          r.done_v = 1'b1;
          r.done_id = run_id;
          run_on = 1'b0;
          run_id = '0;
          run_len = '0;
          run_ticks = '0;
        end
      end
    end
    r.run_v = run_on;
    r.run_id = run_on ? run_id : '0;
    r.queued = COUNT_BITS'(ready_q.size());
  endtask

  task automatic queue_request(input logic kind, input logic [15:0] id,
                               input logic [15:0] len);
    sched_req_t q;
    if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    q.kind = kind;
    q.id = id;
    q.len = len;
    q.gap = tx_calm ? 0 : $urandom_range(0, 12);
    req_backlog.push_back(q);
  endtask

  task automatic queue_tick();
    queue_request(REQ_TICK, 16'($urandom), 16'($urandom));
  endtask

  task automatic queue_arrival(input logic [15:0] id, input logic [15:0] len);
    queue_request(REQ_ARRIVE, id, len);
  endtask

  // request driver
  always @(negedge clk) begin : drive_req
    logic nv;
    sched_req_t q;
    nv = s_axis_tvalid;
    if (req_taken) nv = 1'b0;
    if (!rst && !nv) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (req_backlog.size() > 0) begin
        q = req_backlog.pop_front();
        nv = 1'b1;
        s_axis_tuser <= q.kind;
        s_axis_tdata <= {q.len, q.id};
        tx_gap = q.gap;
      end
    end
    s_axis_tvalid <= nv;
  end

  // result receiver
  always @(negedge clk) begin : drive_ready
    logic rdy;
    rdy = 1'b1;
    if (res_taken) begin
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
      rx_wait = rx_calm ? 0 : $urandom_range(0, 12);
      if (results_seen == 150 || results_seen == 700) hold_left = 300;
    end
    if (rst) begin
      rdy = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      rdy = 1'b0;
    end
    m_axis_tready <= rdy;
  end

  // monitor and checker
  always @(posedge clk) begin : watch
    sched_result_t r;
    sched_result_t want;
    cycles <= cycles + 1;
    req_taken <= !rst && s_axis_tvalid && s_axis_tready;
    res_taken <= !rst && m_axis_tvalid && m_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      schedule_step(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16], r);
      sched_out_q.push_back(r);
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (sched_out_q.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        want = sched_out_q.pop_front();
        compare_field("status", m_axis_tdata[1:0], want.status);
        compare_field("running_valid", m_axis_tdata[2], want.run_v);
        compare_field("running_id", m_axis_tdata[18:3], want.run_id);
        compare_field("done_valid", m_axis_tdata[19], want.done_v);
        compare_field("done_id", m_axis_tdata[35:20], want.done_id);
        compare_field("queued_count", m_axis_tdata[40:36], want.queued);
        compare_field("pad", m_axis_tdata[47:41], 0);
      end
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** shortest_job_next_scheduler_core: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int pct;
    // idle tick with an empty queue, then a rejected zero length
    queue_tick();
    queue_arrival(16'hFFFF, 16'd0);
    queue_tick();
    // ties keep arrival order
    queue_arrival(16'd1, 16'd3);
    queue_arrival(16'd2, 16'd1);
    queue_arrival(16'd3, 16'd3);
    queue_arrival(16'd0, 16'd1);
    queue_tick();
    queue_tick();
    queue_tick();
    // shorter arrival does not preempt
    queue_arrival(16'd5, 16'd2);
    // fill the queue past full, then zero length on a full queue
    queue_arrival(16'hFFFF, 16'd2);
    for (int i = 0; i < 14; i++) begin
      queue_arrival(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 4)));
    end
    queue_arrival(16'h1234, 16'd0);

    // random traffic in bursts of varying arrival density
    for (int b = 0; b < 21; b++) begin
      case ($urandom_range(0, 3))
        0: pct = 15;
        1: pct = 22;
        2: pct = 35;
        default: pct = 60;
      endcase
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(0, 99) < pct) begin
          if ($urandom_range(0, 29) == 0) begin
            queue_arrival(16'($urandom_range(0, 65535)), 16'd0);
          end else if ($urandom_range(0, 15) == 0) begin
            queue_arrival(16'($urandom_range(0, 65535)), 16'($urandom_range(7, 40)));
          end else begin
            queue_arrival(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 6)));
          end
        end else begin
          queue_tick();
        end
      end
    end

    // very long tasks last, so they never hold up the run
    queue_arrival(16'hABCD, 16'hFFFF);
    queue_arrival(16'h0F0F, 16'h8000);
    queue_arrival(16'h5A5A, 16'hFFFF);
    queue_arrival(16'h0001, 16'h7FFF);
    queue_arrival(16'($urandom_range(0, 65535)), 16'($urandom_range(16'h1000, 16'hFFFE)));
    for (int i = 0; i < 6; i++) queue_tick();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_backlog.size() != 0 || s_axis_tvalid || sched_out_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sched_out_q.size() != 0) begin
      report_mismatch("results missing at end of run");
    end
    if (err_count == 0) begin
      $display("** shortest_job_next_scheduler_core: PASSED **");
    end else begin
      $display("** shortest_job_next_scheduler_core: FAILED **");
    end
    $finish;
  end

endmodule
